>>> design/hcc_pkg.sv
// ============================================================================
// hcc_pkg
// Shared types and constants of the Hamiltonian cycle checker: input command
// codes, datapath operation codes and the status bundle from the datapath.
// ============================================================================
package hcc_pkg;

	// Input command codes.
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Reset value of the node count register.
	localparam logic [4:0] NODE_COUNT_RST = 5'd16;

	// Operations that the controller asks of the datapath each cycle.
	typedef enum logic [2:0] {
		DP_NOP,
		DP_EDGE,
		DP_INIT,
		DP_PUSH,
		DP_POP,
		DP_CLEAR
	} dp_op_t;

	// Status that the datapath reports to the controller.
	typedef struct packed {
		logic n_one;     // effective node count is one
		logic n_two;     // effective node count is two
		logic full;      // path holds every node
		logic close_ok;  // last path node is adjacent to node 0
		logic cand_ok;   // an unvisited neighbor is left to try
		logic at_root;   // path holds only node 0
	} dp_status_t;

endpackage

>>> design/hcc_datapath.sv
// ============================================================================
// hcc_datapath
// Adjacency bit matrix, node count register, visited mask and the explicit
// backtracking stack, with the neighbor picker that drives one search step.
// ============================================================================
module hcc_datapath #(
	parameter int MAX_NODES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data,
	input  logic [3:0]          node_a,
	input  logic [3:0]          node_b,
	input  hcc_pkg::dp_op_t     op,
	output hcc_pkg::dp_status_t status
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int NCW   = $clog2(MAX_NODES + 1);
	localparam int CMP_W = 6;
	localparam logic [MAX_NODES-1:0] ONE = MAX_NODES'(1);

	logic [4:0]           node_count_q;
	logic [NCW-1:0]       eff_n;
	logic [MAX_NODES-1:0] adj_q [MAX_NODES];
	logic [MAX_NODES-1:0] visited_q;
	logic [NCW-1:0]       depth_q;
	logic [NW-1:0]        cur_q;
	logic [NCW-1:0]       cand_q;
	logic [NW-1:0]        stk_node_q [MAX_NODES];
	logic [NCW-1:0]       stk_cand_q [MAX_NODES];

	logic                 edge_ok;
	logic [MAX_NODES-1:0] bit_a;
	logic [MAX_NODES-1:0] bit_b;
	logic [MAX_NODES-1:0] row_cur;
	logic [MAX_NODES-1:0] avail;
	logic [NW-1:0]        pick;
	logic [NCW-1:0]       push_idx;
	logic [NCW-1:0]       pop_idx;

	// Node count register, written whenever the port asks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= hcc_pkg::NODE_COUNT_RST;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	// Effective node count: zero acts as one, large values saturate.
	always_comb begin
		if (node_count_q == '0) begin
			eff_n = NCW'(1);
		end else if (CMP_W'(node_count_q) > CMP_W'(MAX_NODES)) begin
			eff_n = NCW'(MAX_NODES);
		end else begin
			eff_n = NCW'(node_count_q);
		end
	end

	// An edge is stored only when both endpoints are in range.
	assign edge_ok = (CMP_W'(node_a) < CMP_W'(eff_n)) && (CMP_W'(node_b) < CMP_W'(eff_n));
	assign bit_a   = ONE << node_a;
	assign bit_b   = ONE << node_b;

	// Adjacency matrix: each row sets its own bits on an edge load.
	for (genvar r = 0; r < MAX_NODES; r++) begin : g_row
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				adj_q[r] <= '0;
			end else if (op == hcc_pkg::DP_CLEAR) begin
				adj_q[r] <= '0;
			end else if (op == hcc_pkg::DP_EDGE && edge_ok) begin
				adj_q[r] <= adj_q[r]
					| ((CMP_W'(node_a) == CMP_W'(r)) ? bit_b : '0)
					| ((CMP_W'(node_b) == CMP_W'(r)) ? bit_a : '0);
			end
		end
	end

	// Unvisited neighbors of the current node, from the resume point up.
	assign row_cur = adj_q[cur_q];
	always_comb begin
		for (int j = 0; j < MAX_NODES; j++) begin
			avail[j] = row_cur[j] && !visited_q[j]
				&& (NCW'(j) >= cand_q) && (NCW'(j) < eff_n);
		end
	end

	// Lowest available neighbor wins.
	always_comb begin
		pick = '0;
		for (int j = MAX_NODES - 1; j >= 0; j--) begin
			if (avail[j]) begin
				pick = NW'(j);
			end
		end
	end

	// Stack slots: push stores the current top below the new one.
	assign push_idx = depth_q - NCW'(1);
	assign pop_idx  = depth_q - NCW'(2);

	// Search control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q   <= '0;
		end else begin
			case (op)
				hcc_pkg::DP_INIT: begin
					visited_q <= ONE;
					depth_q   <= NCW'(1);
				end
				hcc_pkg::DP_PUSH: begin
					visited_q <= visited_q | (ONE << pick);
					depth_q   <= depth_q + NCW'(1);
				end
				hcc_pkg::DP_POP: begin
					visited_q <= visited_q & ~(ONE << cur_q);
					depth_q   <= depth_q - NCW'(1);
				end
				hcc_pkg::DP_CLEAR: begin
					visited_q <= '0;
					depth_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Top of stack and stack storage.
	always_ff @(posedge clk) begin
		case (op)
			hcc_pkg::DP_INIT: begin
				cur_q  <= '0;
				cand_q <= '0;
			end
			hcc_pkg::DP_PUSH: begin
				stk_node_q[push_idx[NW-1:0]] <= cur_q;
				stk_cand_q[push_idx[NW-1:0]] <= NCW'(pick) + NCW'(1);
				cur_q  <= pick;
				cand_q <= '0;
			end
			hcc_pkg::DP_POP: begin
				cur_q  <= stk_node_q[pop_idx[NW-1:0]];
				cand_q <= stk_cand_q[pop_idx[NW-1:0]];
			end
			default: begin
			end
		endcase
	end

	// Status toward the controller.
	assign status.n_one    = (eff_n == NCW'(1));
	assign status.n_two    = (eff_n == NCW'(2));
	assign status.full     = (depth_q == eff_n);
	assign status.close_ok = adj_q[0][cur_q];
	assign status.cand_ok  = |avail;
	assign status.at_root  = (depth_q == NCW'(1));

`ifndef ASSERT_OFF
	a_init_root: assert property (@(posedge clk) disable iff (!arst_n)
		op == hcc_pkg::DP_INIT |=> depth_q == NCW'(1) && visited_q == ONE)
		else $error("search did not start from node 0");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		op == hcc_pkg::DP_CLEAR |=> depth_q == '0 && visited_q == '0 && adj_q[0] == '0)
		else $error("clear left search state behind");
`endif

endmodule

>>> design/hcc_ctrl.sv
// ============================================================================
// hcc_ctrl
// Controller of the checker: takes transactions, sequences the search one
// step per cycle and holds the result in the output register.
// ============================================================================
module hcc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                has_cycle,
	input  hcc_pkg::dp_status_t status,
	output hcc_pkg::dp_op_t     op
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   found_q;
	logic   out_valid_q;
	logic   has_cycle_q;
	logic   in_accept;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign has_cycle = has_cycle_q;

	// Datapath operation for this cycle.
	always_comb begin
		op = hcc_pkg::DP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					if (cmd == hcc_pkg::CMD_EDGE) begin
						op = hcc_pkg::DP_EDGE;
					end else if (!status.n_one && !status.n_two) begin
						op = hcc_pkg::DP_INIT;
					end
				end
			end
			S_SEARCH: begin
				if (status.full) begin
					if (!status.close_ok) begin
						op = hcc_pkg::DP_POP;
					end
				end else if (status.cand_ok) begin
					op = hcc_pkg::DP_PUSH;
				end else if (!status.at_root) begin
					op = hcc_pkg::DP_POP;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					op = hcc_pkg::DP_CLEAR;
				end
			end
			default: begin
			end
		endcase
	end

	// State, search verdict and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			has_cycle_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept && cmd == hcc_pkg::CMD_EVAL) begin
						if (status.n_one || status.n_two) begin
							found_q <= status.n_one;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (status.full && status.close_ok) begin
						found_q <= 1'b1;
						state_q <= S_FINISH;
					end else if (!status.full && !status.cand_ok && status.at_root) begin
						found_q <= 1'b0;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						has_cycle_q <= found_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result appeared without a finished evaluation");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && cmd == hcc_pkg::CMD_EVAL |=> state_q != S_IDLE)
		else $error("evaluate transaction did not start work");

	a_edge_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && cmd == hcc_pkg::CMD_EDGE |=> state_q == S_IDLE)
		else $error("edge load left the idle state");
`endif

endmodule

>>> design/hamiltonian_cycle_check.sv
// ============================================================================
// hamiltonian_cycle_check
// Loads undirected edges into an adjacency matrix and, on evaluate, runs a
// depth-first backtracking search from node 0 for a Hamiltonian cycle.
// ============================================================================
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     cmd, node_a, node_b
// out       output     out_valid / out_stall   has_cycle
// cfg       input      cfg_wr_en               cfg_wr_data (node count)
//
// Edge loads are taken back to back while the checker is idle.
// An evaluation starts the search from node 0, makes one push or pop of the
// search stack per cycle, reaches a verdict, and then posts the result and
// clears the matrix; with one or two nodes the search is skipped. The count
// of stack steps is exponential at worst.
// Reset clears the matrix and sets the node count to 16.
// A result waits in the output register under out_stall; edge loads are
// still taken meanwhile, and a later evaluation holds in its last cycle.
//
module hamiltonian_cycle_check #(
	parameter int MAX_NODES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [3:0] node_a,
	input  logic [3:0] node_b,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       has_cycle
);

	hcc_pkg::dp_op_t     op;
	hcc_pkg::dp_status_t status;

	// Sequencer and output register.
	hcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.has_cycle (has_cycle),
		.status    (status),
		.op        (op)
	);

	// Graph storage and search state.
	hcc_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.node_a      (node_a),
		.node_b      (node_b),
		.op          (op),
		.status      (status)
	);

endmodule
